// ----- hdl/tet_pkg.sv -----
// Package with the types, codes and constants of the timed event table.
`default_nettype none

package tet_pkg;

    // Default number of events the table can hold.
    localparam int TET_CAPACITY = 16;

    localparam int TIME_W = 32;
    localparam int DEST_W = 8;
    localparam int DGRAM_W = 16;

    // Command codes of an input beat.
    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPT  = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_TICKEND = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic [TIME_W-1:0]  due_time;
        logic [DEST_W-1:0]  dest_id;
        logic [DGRAM_W-1:0] datagram_ref;
    } t_cmd_item;

    typedef struct packed {
        t_kind              kind;
        logic [DEST_W-1:0]  out_dest;
        logic [DGRAM_W-1:0] out_datagram;
        logic [TIME_W-1:0]  time_now;
        logic               last;
    } t_result_item;

    // One stored event, as it sits in the table memory.
    typedef struct packed {
        logic [TIME_W-1:0]  due_time;
        logic [DEST_W-1:0]  dest_id;
        logic [DGRAM_W-1:0] datagram_ref;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ----- hdl/timed_event_table_top.sv -----
// Top level of the timed event table: a fixed-capacity list of timed events.
//
//  Channel   Ports                              Direction  Beat taken when
//  --------  ---------------------------------  ---------  ------------------------
//  command   start, busy, i_cmd                 in         start high, busy low
//  result    o_res_valid, o_res                 out        every cycle o_res_valid
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data  in      valid and ready high
//
// A schedule beat's result appears in the cycle after the accepting edge, and
// busy stays low, so schedule beats may follow each other in every cycle. A
// tick holds busy while it scans: it reads the stored entries one after
// another, checks each entry in the step after its read, and then closes the
// scan; on an empty table it only closes the scan. Each delivery appears in
// the cycle after its entry is checked, and the tick-end result appears in
// the first cycle after busy drops.
// The start time is taken only while the block is idle and no command beat is
// offered, so a write never meets a command beat at the same edge.
// Reset is synchronous and active low; it empties the table and clears the
// current time to zero. The table memory itself needs no clearing.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none

module timed_event_table_top #(
    parameter int CAPACITY = tet_pkg::TET_CAPACITY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Command channel.
    input  wire logic                  start,
    output logic                       busy,
    input  wire tet_pkg::t_cmd_item    i_cmd,
    // Result channel.
    output logic                       o_res_valid,
    output tet_pkg::t_result_item      o_res,
    // Configuration channel: the start time.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [tet_pkg::TIME_W-1:0] i_cfg_data
);

    import tet_pkg::*;

    // Address width of the table and width of a counter that can hold CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state r_state, n_state;

    // Number of stored events and the current time.
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TIME_W-1:0] r_time, n_time;

    // Scan pointers: r_rd is the next entry to read, r_wr is where the next
    // kept entry is written back. Kept entries are compacted toward the front,
    // which removes the delivered ones while the order of the others stays.
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_wr, n_wr;
    // High when the memory read data holds an entry issued in the last cycle.
    logic              r_pv, n_pv;

    logic              r_res_valid, n_res_valid;
    t_result_item      r_res, n_res;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    t_entry            ram_rdata;

    logic              accept;
    logic              cfg_write;
    logic              scan_done;

    tet_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !start;
    assign accept      = start && !busy;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // The scan ends once every entry has been read and the last read has
    // been processed.
    assign scan_done = (r_rd == r_count) && !r_pv;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd.cmd == CMD_TICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_time      = r_time;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_pv        = 1'b0;
        n_res_valid = 1'b0;
        n_res       = '{kind: KIND_ACCEPT, out_dest: '0, out_datagram: '0,
                        time_now: r_time, last: 1'b1};
        ram_we      = 1'b0;
        ram_waddr   = r_wr[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_rd[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (cfg_write) begin
                    n_time = i_cfg_data;
                end
                if (accept) begin
                    if (i_cmd.cmd == CMD_SCHEDULE) begin
                        // Append at the end of the table, or reject when full.
                        n_res_valid = 1'b1;
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_res.kind = KIND_REJECT;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[AW-1:0];
                            ram_wdata = '{due_time: i_cmd.due_time,
                                          dest_id: i_cmd.dest_id,
                                          datagram_ref: i_cmd.datagram_ref};
                            n_count   = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_rd = '0;
                        n_wr = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd != r_count) begin
                    n_rd = r_rd + CNT_W'(1);
                    n_pv = 1'b1;
                end
                if (r_pv) begin
                    if (ram_rdata.due_time == r_time) begin
                        n_res_valid        = 1'b1;
                        n_res.kind         = KIND_DELIVER;
                        n_res.out_dest     = ram_rdata.dest_id;
                        n_res.out_datagram = ram_rdata.datagram_ref;
                        n_res.last         = 1'b0;
                    end else begin
                        // The write lands at or behind the entry just read,
                        // never on an entry still to be read.
                        ram_we = 1'b1;
                        n_wr   = r_wr + CNT_W'(1);
                    end
                end
                if (scan_done) begin
                    n_res_valid = 1'b1;
                    n_res.kind  = KIND_TICKEND;
                    n_count     = r_wr;
                    n_time      = r_time + TIME_W'(1);
                end
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_time      <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_pv        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_time      <= n_time;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_pv        <= n_pv;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // The table never holds more events than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("event count exceeds capacity");

    // Compaction writes only behind the read pointer, so no unread entry is lost.
    a_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == ST_SCAN) |-> (r_wr < r_rd))
        else $error("scan write-back overtook the read pointer");

    // An accepted tick keeps the block busy in the next cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.cmd == CMD_TICK) |=> busy)
        else $error("tick accepted but block not busy");

    // The tick end closes the scan: the block is idle when it is shown.
    a_tickend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_TICKEND) |-> !busy)
        else $error("tick end shown while still scanning");

    // Deliveries are shown only during a scan, never at the start of one.
    a_deliver_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_DELIVER) |-> (busy && $past(busy)))
        else $error("delivery outside a tick");

endmodule

`default_nettype wire

// ----- hdl/tet_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module tet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
